/* hdl/pfe_pkg.sv */
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types and constants for the protocol buffers field encoder:
// mode codes, wire types, controller states, and the controller/datapath
// command and status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package pfe_pkg;

  // item modes
  localparam logic [2:0] MODE_VARINT    = 3'd0;
  localparam logic [2:0] MODE_ZIGZAG    = 3'd1;
  localparam logic [2:0] MODE_FIXED32   = 3'd2;
  localparam logic [2:0] MODE_FIXED64   = 3'd3;
  localparam logic [2:0] MODE_LEN_DELIM = 3'd4;
  localparam logic [2:0] MODE_PAYLOAD   = 3'd5;

  // wire types carried in the low three bits of the tag
  localparam logic [2:0] WT_VARINT   = 3'd0;
  localparam logic [2:0] WT_FIXED64  = 3'd1;
  localparam logic [2:0] WT_LENDELIM = 3'd2;
  localparam logic [2:0] WT_FIXED32  = 3'd5;

  localparam int TagW   = 32;
  localparam int ValueW = 64;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TAG,
    ST_VALUE,
    ST_PAYLOAD
  } state_t;

  // which source feeds the output register
  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_TAG,
    EMIT_VALUE,
    EMIT_PAYLOAD
  } emit_t;

  typedef struct packed {
    logic  load;
    emit_t emit;
  } pfe_cmd_t;

  typedef struct packed {
    logic out_free;
    logic tag_last;
    logic value_last;
  } pfe_status_t;

  // wire type for a field mode
  function automatic logic [2:0] wire_type(input logic [2:0] mode);
    logic [2:0] wt;
    case (mode)
      MODE_FIXED32:   wt = WT_FIXED32;
      MODE_FIXED64:   wt = WT_FIXED64;
      MODE_LEN_DELIM: wt = WT_LENDELIM;
      default:        wt = WT_VARINT;
    endcase
    return wt;
  endfunction

endpackage

`default_nettype wire

/* hdl/pfe_field_if.sv */
// ----------------------------------------------------------------------------
// pfe_field_if
// Valid/ready channel carrying one field encode request.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfe_field_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [28:0] field_number;
  logic [63:0] value;
  logic [7:0]  payload_byte;

  modport source (output valid, output mode, output field_number, output value,
                  output payload_byte, input ready);
  modport sink   (input valid, input mode, input field_number, input value,
                  input payload_byte, output ready);
endinterface

`default_nettype wire

/* hdl/pfe_byte_if.sv */
// ----------------------------------------------------------------------------
// pfe_byte_if
// Valid/ready channel carrying one wire stream byte and its last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

/* hdl/pfe_ctrl.sv */
// ----------------------------------------------------------------------------
// pfe_ctrl
// Controller: accepts a request, then steps through tag bytes, value bytes
// or the single payload byte, one byte per free output slot.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic [2:0]          req_mode,
  output logic                req_ready,
  input  pfe_pkg::pfe_status_t status,
  output pfe_pkg::pfe_cmd_t    cmd
);
  import pfe_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.emit   = EMIT_NONE;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load = 1'b1;
          case (req_mode)
            MODE_VARINT, MODE_ZIGZAG, MODE_FIXED32, MODE_FIXED64,
            MODE_LEN_DELIM: state_next = ST_TAG;
            MODE_PAYLOAD:   state_next = ST_PAYLOAD;
            default:        state_next = ST_IDLE;  // unused modes are dropped
          endcase
        end
      end
      ST_TAG: begin
        if (status.out_free) begin
          cmd.emit = EMIT_TAG;
          if (status.tag_last) state_next = ST_VALUE;
        end
      end
      ST_VALUE: begin
        if (status.out_free) begin
          cmd.emit = EMIT_VALUE;
          if (status.value_last) state_next = ST_IDLE;
        end
      end
      ST_PAYLOAD: begin
        if (status.out_free) begin
          cmd.emit   = EMIT_PAYLOAD;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/pfe_datapath.sv */
// ----------------------------------------------------------------------------
// pfe_datapath
// Tag and value shift registers, fixed byte counter and the output
// register that holds one byte until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [2:0]           mode,
  input  logic [28:0]          field_number,
  input  logic [63:0]          value,
  input  logic [7:0]           payload_byte,
  input  pfe_pkg::pfe_cmd_t    cmd,
  output pfe_pkg::pfe_status_t status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 last
);
  import pfe_pkg::*;

  logic [TagW-1:0]   tag;
  logic [ValueW-1:0] val;
  logic              fixed;
  logic [3:0]        cnt;
  logic [7:0]        pay;
  logic [ValueW-1:0] zigzag;

  assign zigzag = {value[ValueW-2:0], 1'b0} ^ {ValueW{value[ValueW-1]}};

  // status toward the controller
  assign status.out_free   = !out_valid || out_ready;
  assign status.tag_last   = (tag[TagW-1:7] == '0);
  assign status.value_last = fixed ? (cnt == 4'd1) : (val[ValueW-1:7] == '0);

  // item registers: load on accept, shift as bytes go out
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tag   <= {field_number, wire_type(mode)};
      fixed <= (mode == MODE_FIXED32) || (mode == MODE_FIXED64);
      cnt   <= (mode == MODE_FIXED64) ? 4'd8 : 4'd4;
      pay   <= payload_byte;
      case (mode)
        MODE_ZIGZAG:  val <= zigzag;
        MODE_FIXED32: val <= {32'd0, value[31:0]};
        default:      val <= value;
      endcase
    end else begin
      if (cmd.emit == EMIT_TAG) tag <= tag >> 7;
      if (cmd.emit == EMIT_VALUE) begin
        if (fixed) begin
          val <= val >> 8;
          cnt <= cnt - 4'd1;
        end else begin
          val <= val >> 7;
        end
      end
    end
  end

  // output byte register
  always_ff @(posedge clk) begin
    case (cmd.emit)
      EMIT_TAG: begin
        out_byte <= {!status.tag_last, tag[6:0]};
        last     <= 1'b0;
      end
      EMIT_VALUE: begin
        out_byte <= fixed ? val[7:0] : {!status.value_last, val[6:0]};
        last     <= status.value_last;
      end
      EMIT_PAYLOAD: begin
        out_byte <= pay;
        last     <= 1'b1;
      end
      default: ;
    endcase
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit != EMIT_NONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* hdl/protobuf_field_encoder_core.sv */
// ----------------------------------------------------------------------------
// protobuf_field_encoder_core
// Protocol buffers wire format encoder, one field per request transaction.
// ----------------------------------------------------------------------------
// Each request encodes one field (tag varint then a varint, zigzag varint,
// little-endian fixed32/fixed64 value or length varint) or passes one raw
// payload byte, and produces one byte transaction per wire byte, with last
// set on the final byte of the item. Bytes leave through a single output
// register at one per cycle when the downstream side is ready; a payload
// item is one byte and a 64-bit varint field up to 15 bytes (tag 1-5
// bytes, value 1-10 bytes). The next request is accepted as soon as the
// final byte of the current item sits in the output register. Modes 6
// and 7 are consumed and produce no bytes.
`default_nettype none

module protobuf_field_encoder_core (
  input  logic        clk,
  input  logic        rst,
  pfe_field_if.sink   field_req,
  pfe_byte_if.source  byte_stream
);
  import pfe_pkg::*;

  pfe_cmd_t    cmd;
  pfe_status_t status;
  logic        req_ready;

  assign field_req.ready = req_ready;

  // sequencing
  pfe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (field_req.valid),
    .req_mode  (field_req.mode),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // byte generation
  pfe_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .mode         (field_req.mode),
    .field_number (field_req.field_number),
    .value        (field_req.value),
    .payload_byte (field_req.payload_byte),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (byte_stream.valid),
    .out_ready    (byte_stream.ready),
    .out_byte     (byte_stream.out_byte),
    .last         (byte_stream.last)
  );

endmodule

`default_nettype wire

/* hdl/pfe_checker.sv */
// ----------------------------------------------------------------------------
// pfe_checker
// Port-level checks for the field encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [2:0] in_mode,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last
);
  import pfe_pkg::*;

  // a stalled byte holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
    else $error("output byte changed while stalled");

  // nothing is offered right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // an accepted field request leaves the request channel closed
  a_field_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_mode == MODE_VARINT || in_mode == MODE_ZIGZAG ||
    in_mode == MODE_FIXED32 || in_mode == MODE_FIXED64 ||
    in_mode == MODE_LEN_DELIM) |=> !in_ready)
    else $error("request accepted in the middle of a field");

  // unused modes are consumed without work
  a_unused_mode: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !(in_mode == MODE_VARINT || in_mode == MODE_ZIGZAG ||
    in_mode == MODE_FIXED32 || in_mode == MODE_FIXED64 ||
    in_mode == MODE_LEN_DELIM || in_mode == MODE_PAYLOAD) |=> in_ready)
    else $error("unused mode stalled the request channel");

  // request channel stays closed while a non-final byte waits in the output
  a_mid_item: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("request channel opened before the final byte");

endmodule

bind protobuf_field_encoder_core pfe_checker u_pfe_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (field_req.valid),
  .in_ready  (field_req.ready),
  .in_mode   (field_req.mode),
  .out_valid (byte_stream.valid),
  .out_ready (byte_stream.ready),
  .out_byte  (byte_stream.out_byte),
  .last      (byte_stream.last)
);

`default_nettype wire

/* tb/protobuf_field_encoder_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// protobuf_field_encoder_core_test
// Self-checking bench for the protocol buffers field encoder. Field requests
// (directed corner cases, then random fields and header/payload runs) are
// driven over the request channel. A scoreboard encodes each accepted
// request into its expected wire bytes and compares every byte transaction
// in order, with random stalls on both channels.
// ----------------------------------------------------------------------------

module protobuf_field_encoder_core_test;
  import pfe_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } wire_byte_t;

  // expected wire bytes, encoded from each accepted request
  class wire_byte_board;
    wire_byte_t expected_q[$];
    int         errors = 0;

    task report(string msg);
      errors++;
      $display("%0t: %s", $time, msg);
    endtask

    function void push_byte(logic [7:0] data);
      wire_byte_t wb;
      wb.data = data;
      wb.last = 1'b0;
      expected_q.push_back(wb);
    endfunction

    // 7 bits per byte, low group first, continuation bit on all but the end
    function void push_varint(logic [63:0] v);
      do begin
        if (v > 64'd127) push_byte({1'b1, v[6:0]});
        else push_byte(v[7:0]);
        v = v >> 7;
      end while (v != 64'd0);
    endfunction

    function void push_le(logic [63:0] v, int nbytes);
      for (int i = 0; i < nbytes; i++) push_byte(v[8*i +: 8]);
    endfunction

    function void note_field(logic [2:0] mode, logic [28:0] fnum, logic [63:0] val,
                             logic [7:0] pbyte);
      wire_byte_t wb;
      logic [63:0] zz;
      case (mode)
        MODE_VARINT: begin
          push_varint(64'({fnum, WT_VARINT}));
          push_varint(val);
        end
        MODE_ZIGZAG: begin
          zz = (val << 1) ^ {64{val[63]}};
          push_varint(64'({fnum, WT_VARINT}));
          push_varint(zz);
        end
        MODE_FIXED32: begin
          push_varint(64'({fnum, WT_FIXED32}));
          push_le(val, 4);
        end
        MODE_FIXED64: begin
          push_varint(64'({fnum, WT_FIXED64}));
          push_le(val, 8);
        end
        MODE_LEN_DELIM: begin
          push_varint(64'({fnum, WT_LENDELIM}));
          push_varint(val);
        end
        MODE_PAYLOAD: push_byte(pbyte);
        default: return;
      endcase
      // flag the final byte of the item
      wb = expected_q.pop_back();
      wb.last = 1'b1;
      expected_q.push_back(wb);
    endfunction

    task check_byte(logic [7:0] data, logic last);
      wire_byte_t wb;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected byte 0x%02h last %0b", data, last));
        return;
      end
      wb = expected_q.pop_front();
      if (data !== wb.data)
        report($sformatf("out_byte 0x%02h, want 0x%02h", data, wb.data));
      if (last !== wb.last)
        report($sformatf("last %0b, want %0b (byte 0x%02h)", last, wb.last, wb.data));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  int   src_idle_pct;
  int   snk_idle_pct;

  pfe_field_if field_req ();
  pfe_byte_if  byte_stream ();

  wire_byte_board board = new;

  protobuf_field_encoder_core u_top (
    .clk        (clk),
    .rst        (rst),
    .field_req  (field_req),
    .byte_stream(byte_stream)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // byte sink with random stalls
  initial begin
    byte_stream.ready = 1'b0;
    forever begin
      @(negedge clk);
      byte_stream.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // compare every byte transaction
  always @(posedge clk) begin
    if (!rst && byte_stream.valid && byte_stream.ready)
      board.check_byte(byte_stream.out_byte, byte_stream.last);
  end

  // run limit
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // random value with only the low w bits possibly set
  function automatic logic [63:0] rand_bits(int w);
    logic [63:0] v;
    v = {$urandom, $urandom};
    if (w < 64) v = v & ((64'h1 << w) - 64'h1);
    return v;
  endfunction

  function automatic int rand_width(int wmax);
    if ($urandom_range(3) == 0) return wmax;
    return $urandom_range(wmax);
  endfunction

  // one request transaction; entered and left at a falling edge
  task automatic send_field(logic [2:0] mode, logic [28:0] fnum, logic [63:0] val,
                            logic [7:0] pbyte);
    while ($urandom_range(99) < src_idle_pct) begin
      field_req.valid <= 1'b0;
      @(negedge clk);
    end
    field_req.valid        <= 1'b1;
    field_req.mode         <= mode;
    field_req.field_number <= fnum;
    field_req.value        <= val;
    field_req.payload_byte <= pbyte;
    do @(posedge clk); while (!field_req.ready);
    board.note_field(mode, fnum, val, pbyte);
    @(negedge clk);
  endtask

  task automatic send_random_field(logic [2:0] mode);
    send_field(mode, 29'(rand_bits(rand_width(29))), rand_bits(rand_width(64)),
               8'($urandom));
  endtask

  // mix of single fields, header plus payload runs and unused modes
  task automatic run_random_phase(int n_fields);
    int sent;
    int pick;
    int len;
    sent = 0;
    while (sent < n_fields) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        len = $urandom_range(6);
        send_field(MODE_LEN_DELIM, 29'(rand_bits(rand_width(29))), 64'(len),
                   8'($urandom));
        repeat (len) send_random_field(MODE_PAYLOAD);
        sent += len + 1;
      end else if (pick < 28) begin
        send_random_field(3'($urandom_range(6, 7)));
      end else begin
        send_random_field(3'($urandom_range(MODE_VARINT, MODE_PAYLOAD)));
        sent++;
      end
    end
  endtask

  initial begin
    rst                      = 1'b1;
    src_idle_pct             = 34;
    snk_idle_pct             = 76;
    field_req.valid          = 1'b0;
    field_req.mode           = MODE_VARINT;
    field_req.field_number   = '0;
    field_req.value          = '0;
    field_req.payload_byte   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed corner cases
    send_field(MODE_VARINT, 29'd0, 64'd0, 8'h00);
    send_field(MODE_VARINT, '1, '1, 8'hff);
    send_field(MODE_VARINT, 29'd15, 64'd127, 8'h00);
    send_field(MODE_VARINT, 29'd16, 64'd128, 8'h00);
    send_field(MODE_ZIGZAG, 29'd1, 64'd0, 8'h00);
    send_field(MODE_ZIGZAG, 29'd2, '1, 8'h00);
    send_field(MODE_ZIGZAG, 29'd3, 64'h7fff_ffff_ffff_ffff, 8'h00);
    send_field(MODE_ZIGZAG, '1, 64'h8000_0000_0000_0000, 8'h00);
    send_field(MODE_FIXED32, 29'd0, '1, 8'h00);
    send_field(MODE_FIXED32, 29'd5, 64'h0123_4567_89ab_cdef, 8'h00);
    send_field(MODE_FIXED64, '1, 64'h8000_0000_0000_0001, 8'h00);
    send_field(MODE_FIXED64, 29'd0, 64'd0, 8'h00);
    send_field(MODE_LEN_DELIM, 29'd1, 64'd0, 8'h00);
    send_field(MODE_LEN_DELIM, 29'd2047, 64'd127, 8'h00);
    send_field(MODE_LEN_DELIM, 29'd2048, 64'd128, 8'h00);
    send_field(MODE_LEN_DELIM, '1, '1, 8'h00);
    send_field(MODE_PAYLOAD, 29'd0, 64'd0, 8'h00);
    send_field(MODE_PAYLOAD, '1, '1, 8'hff);
    send_field(MODE_PAYLOAD, 29'h0aaa_aaaa, 64'h5555_5555_5555_5555, 8'h5a);
    // unused modes produce nothing
    send_field(3'd6, 29'd1, 64'd1, 8'h11);
    send_field(3'd7, '1, '1, 8'hff);
    send_field(MODE_VARINT, 29'd1, 64'd150, 8'h00);

    // random traffic, idling sender/receiver then swapped, then none
    run_random_phase(150);
    src_idle_pct = 76;
    snk_idle_pct = 34;
    run_random_phase(150);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_random_phase(150);
    field_req.valid <= 1'b0;

    // drain, then watch for stray bytes
    while (board.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
